@@ sv/abt_pkg.sv @@
// ----------------------------------------------------------------------------
// abt_pkg
// Types and constants shared by the audio beat level tracker.
// ----------------------------------------------------------------------------
package abt_pkg;

  localparam int unsigned VolW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ScaleW = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_SILENCE_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_RISE          = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BUMP_SCALE        = 2'd2;

  localparam logic [VolW-1:0]   SILENCE_THRESHOLD_RST = 16'd0;
  localparam logic [VolW-1:0]   MIN_RISE_RST          = 16'd3277;
  localparam logic [ScaleW-1:0] BUMP_SCALE_RST        = 9'd230;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [VolW-1:0]  volume;
    logic [TimeW-1:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [VolW-1:0]  gated_volume;
    logic [VolW-1:0]  average_volume;
    logic [VolW-1:0]  peak_volume;
    logic             beat;
    logic [TimeW-1:0] beat_interval_ms;
  } out_t;

  typedef struct packed {
    logic [VolW-1:0]  previous_volume;
    logic [VolW-1:0]  running_average;
    logic [VolW-1:0]  running_peak;
    logic [VolW-1:0]  average_rise;
    logic [TimeW-1:0] last_beat_time;
    logic [TimeW-1:0] average_interval;
  } state_t;

  typedef struct packed {
    logic [VolW-1:0]   silence_threshold;
    logic [VolW-1:0]   min_rise;
    logic [ScaleW-1:0] bump_scale;
  } cfg_t;

endpackage

@@ sv/abt_if.sv @@
// ----------------------------------------------------------------------------
// abt_if
// Valid/ready stream interfaces for samples in and results out.
// ----------------------------------------------------------------------------
interface abt_in_if;
  import abt_pkg::*;

  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface abt_out_if;
  import abt_pkg::*;

  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/audio_beat_level_tracker.sv @@
// ----------------------------------------------------------------------------
// audio_beat_level_tracker
// Volume gating, running average and peak, and beat detection per sample.
//
//   channel    dir   payload                                        handshake
//   sample_i   in    command, volume, time_ms                       valid/ready
//   result_o   out   gated_volume, average_volume, peak_volume,     valid/ready
//                    beat, beat_interval_ms
//   cfg_*      in    cfg_idx_i, cfg_wdata_i                         cfg_we_i
//
// one sample per cycle sustained while results are taken; the result passes
// through the input register, then the single-pass update into the result
// register before it is valid
// the tracked state is read and rewritten by the update in the same cycle
// reset clears all tracked state and loads register defaults
// a stalled result holds the input register; a new sample still transfers
// when the result is taken in the same cycle
// ----------------------------------------------------------------------------
module audio_beat_level_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  abt_in_if.sink                       sample_i,
  abt_out_if.source                    result_o,
  input  logic                         cfg_we_i,
  input  logic [abt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [abt_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import abt_pkg::*;

  cfg_t   cfg;
  state_t state_q, state_d;
  in_t    item_q;
  out_t   res_d, res_q;
  logic   item_valid_q, item_valid_d;
  logic   out_valid_q, out_valid_d;
  logic   advance;
  logic   in_ready;
  logic   in_xfer;

  abt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  abt_update u_update (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign advance  = item_valid_q && (!out_valid_q || result_o.ready);
  assign in_ready = !item_valid_q || advance;
  assign in_xfer  = sample_i.valid && in_ready;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_xfer) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      state_q      <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= sample_i.payload;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign sample_i.ready   = in_ready;
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = res_q;

  a_beat_has_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.beat) |-> (res_q.gated_volume != '0))
    else $error("beat reported with zero gated volume");

  a_peak_covers_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.peak_volume >= res_q.gated_volume))
    else $error("peak below gated volume");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && out_valid_q && !result_o.ready) |-> !sample_i.ready)
    else $error("input accepted while both stages are stalled");

  a_state_held_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("tracked state changed without an update");

endmodule

@@ sv/abt_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// abt_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module abt_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [abt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [abt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output abt_pkg::cfg_t                  cfg_o
);
  import abt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SILENCE_THRESHOLD: cfg_d.silence_threshold = cfg_wdata_i[VolW-1:0];
        CFG_MIN_RISE:          cfg_d.min_rise = cfg_wdata_i[VolW-1:0];
        CFG_BUMP_SCALE:        cfg_d.bump_scale = cfg_wdata_i[ScaleW-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.silence_threshold <= SILENCE_THRESHOLD_RST;
      cfg_q.min_rise          <= MIN_RISE_RST;
      cfg_q.bump_scale        <= BUMP_SCALE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/abt_update.sv @@
// ----------------------------------------------------------------------------
// abt_update
// Single-pass update: gating, average, peak, rise, beat test and interval, or clear.
// ----------------------------------------------------------------------------
module abt_update (
  input  abt_pkg::in_t    item_i,
  input  abt_pkg::state_t state_i,
  input  abt_pkg::cfg_t   cfg_i,
  output abt_pkg::state_t state_o,
  output abt_pkg::out_t   result_o
);
  import abt_pkg::*;

  localparam int unsigned ProdW = VolW + ScaleW;

  logic                   silent;
  logic [VolW-1:0]        gated;
  logic [VolW:0]          avg_sum;
  logic [VolW-1:0]        avg_n;
  logic [VolW:0]          avg_peak_sum;
  logic [VolW:0]          gated_peak_sum;
  logic [VolW-1:0]        peak_n;
  logic signed [VolW:0]   rise;
  logic                   rise_big;
  logic [VolW:0]          rise_sum;
  logic [VolW-1:0]        arise_n;
  logic [ProdW-1:0]       prod;
  logic [ProdW-1:0]       rise_scaled;
  logic                   beat;
  logic [TimeW-1:0]       span;
  logic [TimeW:0]         int_sum;

  always_comb begin
    silent = ({item_i.volume, 1'b0} < {1'b0, state_i.running_average}) ||
             (item_i.volume < cfg_i.silence_threshold);
    gated  = silent ? '0 : item_i.volume;

    avg_sum = {1'b0, state_i.running_average} + {1'b0, item_i.volume};
    avg_n   = silent ? state_i.running_average : avg_sum[VolW:1];

    avg_peak_sum   = {1'b0, avg_n} + {1'b0, state_i.running_peak};
    gated_peak_sum = {1'b0, gated} + {1'b0, state_i.running_peak};
    if (gated > state_i.running_peak) begin
      peak_n = gated;
    end else if ({gated, 1'b0} > avg_peak_sum) begin
      peak_n = gated_peak_sum[VolW:1];
    end else begin
      peak_n = state_i.running_peak;
    end

    rise     = $signed({1'b0, gated}) - $signed({1'b0, state_i.previous_volume});
    rise_big = rise > $signed({1'b0, cfg_i.min_rise});
    rise_sum = {1'b0, state_i.average_rise} + $unsigned(rise);
    arise_n  = rise_big ? rise_sum[VolW:1] : state_i.average_rise;

    prod        = ProdW'(arise_n) * ProdW'(cfg_i.bump_scale);
    rise_scaled = ProdW'({rise[VolW-1:0], 8'b0});
    beat        = !rise[VolW] && (rise_scaled > prod);

    span    = item_i.time_ms - state_i.last_beat_time;
    int_sum = {1'b0, span} + {1'b0, state_i.average_interval};

    state_o.previous_volume  = gated;
    state_o.running_average  = avg_n;
    state_o.running_peak     = peak_n;
    state_o.average_rise     = arise_n;
    state_o.last_beat_time   = beat ? item_i.time_ms : state_i.last_beat_time;
    state_o.average_interval = beat ? int_sum[TimeW:1] : state_i.average_interval;

    if (item_i.command == CMD_CLEAR) begin
      state_o = '0;
      gated   = '0;
      beat    = 1'b0;
    end

    result_o.gated_volume     = gated;
    result_o.average_volume   = state_o.running_average;
    result_o.peak_volume      = state_o.running_peak;
    result_o.beat             = beat;
    result_o.beat_interval_ms = state_o.average_interval;
  end

endmodule
